@@ design/usb_in_data_packetizer_assert.svh @@
// Assertion macros for the USB IN data packetizer.
`ifndef USB_IN_DATA_PACKETIZER_ASSERT_SVH
`define USB_IN_DATA_PACKETIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define UIDP_ASSERT_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("uidp assertion failed");

`define UIDP_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("uidp assertion failed");

`else

`define UIDP_ASSERT_IMPL(lbl, ant, cons)

`define UIDP_ASSERT_NEXT(lbl, ant, cons)

`endif

`endif

@@ design/uidp_pkg.sv @@
// Package with types, constants and the CRC16 step of the USB IN data packetizer.
`default_nettype none

package uidp_pkg;

  localparam int MaxPacket = 8;
  localparam int PktW      = 4;
  localparam int CntW      = 16;
  localparam int EpW       = 4;
  localparam int MaxBeats  = 3;
  localparam int BeatIdxW  = 2;

  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  typedef enum logic [1:0] {
    ReqStart     = 2'd0,
    ReqData      = 2'd1,
    ReqAck       = 2'd2,
    ReqToggleRst = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StBusy       = 2'd1,
    StUnexpected = 2'd2
  } status_e;

  typedef struct packed {
    status_e    status;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [BeatIdxW-1:0]        cnt;
    beat_t [MaxBeats-1:0]       beats;
    logic                       pid_data1;
    logic [EpW-1:0]             endpoint;
    logic                       transfer_done;
  } bundle_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic [7:0]  b;
    c = crc;
    b = data;
    for (int i = 0; i < 8; i++) begin
      if ((c[0] ^ b[0]) == 1'b1) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
      b = b >> 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/uidp_engine.sv @@
// Input register, transfer state and per-beat packet logic.
`default_nettype none

module uidp_engine
  import uidp_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire logic [1:0]     in_req_i,
  input  wire logic [EpW-1:0] in_ep_i,
  input  wire logic [CntW-1:0] in_tlen_i,
  input  wire logic [CntW-1:0] in_mlen_i,
  input  wire logic [7:0]     in_byte_i,
  output      logic           bundle_valid_o,
  input  wire logic           bundle_ready_i,
  output      bundle_t        bundle_o
);

  logic            in_valid_q;
  req_e            in_req_q;
  logic [EpW-1:0]  in_ep_q;
  logic [CntW-1:0] in_tlen_q, in_mlen_q;
  logic [7:0]      in_byte_q;

  logic [CntW-1:0] bytes_left_q, bytes_left_d;
  logic [CntW-1:0] max_left_q, max_left_d;
  logic            active_q, active_d;
  logic            pending_q, pending_d;
  logic            toggle_q, toggle_d;
  logic [EpW-1:0]  ep_q, ep_d;
  logic [PktW-1:0] size_q, size_d;
  logic [PktW-1:0] pos_q, pos_d;
  logic [15:0]     crc_q, crc_d;

  logic            fire;
  logic            prep;
  logic [15:0]     crc_nx;
  logic [PktW-1:0] sz;
  bundle_t         bnd;

  assign fire           = in_valid_q & bundle_ready_i;
  assign in_ready_o     = ~in_valid_q | bundle_ready_i;
  assign bundle_valid_o = in_valid_q;
  assign bundle_o       = bnd;

  always_comb begin
    bytes_left_d = bytes_left_q;
    max_left_d   = max_left_q;
    active_d     = active_q;
    pending_d    = pending_q;
    toggle_d     = toggle_q;
    ep_d         = ep_q;
    size_d       = size_q;
    pos_d        = pos_q;
    crc_d        = crc_q;
    prep         = 1'b0;
    crc_nx       = crc16_byte(crc_q, in_byte_q);
    sz           = PktW'(MaxPacket);
    bnd          = '0;
    bnd.cnt      = BeatIdxW'(1);

    case (in_req_q)
      ReqStart: begin
        if (active_q) begin
          bnd.beats[0].status = StBusy;
        end else begin
          ep_d         = in_ep_q;
          bytes_left_d = in_tlen_q;
          max_left_d   = in_mlen_q;
          active_d     = 1'b1;
          pending_d    = 1'b0;
          prep         = 1'b1;
        end
      end
      ReqData: begin
        if (active_q && pending_q && (pos_q < size_q)) begin
          crc_d                   = crc_nx;
          pos_d                   = pos_q + PktW'(1);
          bnd.beats[0].byte_valid = 1'b1;
          bnd.beats[0].out_byte   = in_byte_q;
          if (pos_d == size_q) begin
            bnd.cnt                 = BeatIdxW'(3);
            bnd.beats[1].byte_valid = 1'b1;
            bnd.beats[1].out_byte   = ~crc_nx[7:0];
            bnd.beats[2].byte_valid = 1'b1;
            bnd.beats[2].out_byte   = ~crc_nx[15:8];
            bnd.beats[2].last       = 1'b1;
          end
        end else begin
          bnd.beats[0].status = StUnexpected;
        end
      end
      ReqAck: begin
        if ((bytes_left_q < CntW'(MaxPacket)) || (max_left_q < CntW'(MaxPacket))) begin
          bytes_left_d = '0;
          max_left_d   = '0;
          active_d     = 1'b0;
        end else begin
          bytes_left_d = bytes_left_q - CntW'(MaxPacket);
          max_left_d   = max_left_q - CntW'(MaxPacket);
        end
        pending_d = 1'b0;
        prep      = 1'b1;
      end
      ReqToggleRst: begin
        toggle_d = 1'b0;
      end
      default: begin
        bnd.beats[0].status = StUnexpected;
      end
    endcase

    if (prep && active_d && !pending_d) begin
      toggle_d = ~toggle_q;
      pos_d    = '0;
      crc_d    = CrcInit;
      if ((bytes_left_d == '0) || (max_left_d == '0)) begin
        if (ep_d != '0) begin
          active_d = 1'b0;
        end else begin
          pending_d               = 1'b1;
          size_d                  = '0;
          bnd.cnt                 = BeatIdxW'(2);
          bnd.beats[0].byte_valid = 1'b1;
          bnd.beats[1].byte_valid = 1'b1;
          bnd.beats[1].last       = 1'b1;
        end
      end else begin
        if (bytes_left_d < CntW'(sz)) begin
          sz = bytes_left_d[PktW-1:0];
        end
        if (max_left_d < CntW'(sz)) begin
          sz = max_left_d[PktW-1:0];
        end
        size_d    = sz;
        pending_d = 1'b1;
      end
    end

    bnd.pid_data1     = toggle_d;
    bnd.endpoint      = ep_d;
    bnd.transfer_done = ~active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_req_q  <= req_e'(in_req_i);
      in_ep_q   <= in_ep_i;
      in_tlen_q <= in_tlen_i;
      in_mlen_q <= in_mlen_i;
      in_byte_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      max_left_q   <= '0;
      active_q     <= 1'b0;
      pending_q    <= 1'b0;
      toggle_q     <= 1'b0;
      ep_q         <= '0;
      size_q       <= '0;
      pos_q        <= '0;
      crc_q        <= CrcInit;
    end else if (fire) begin
      bytes_left_q <= bytes_left_d;
      max_left_q   <= max_left_d;
      active_q     <= active_d;
      pending_q    <= pending_d;
      toggle_q     <= toggle_d;
      ep_q         <= ep_d;
      size_q       <= size_d;
      pos_q        <= pos_d;
      crc_q        <= crc_d;
    end
  end

endmodule

`default_nettype wire

@@ design/uidp_serializer.sv @@
// Result register that sends the one to three beats of an item in order.
`default_nettype none

module uidp_serializer
  import uidp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    bundle_valid_i,
  output      logic    bundle_ready_o,
  input  wire bundle_t bundle_i,
  output      logic    out_valid_o,
  input  wire logic    out_ready_i,
  output      beat_t   out_beat_o,
  output      logic    out_pid_o,
  output      logic [EpW-1:0] out_ep_o,
  output      logic    out_done_o
);

  bundle_t             bundle_q;
  logic                valid_q;
  logic [BeatIdxW-1:0] idx_q;
  logic                last_beat;

  assign last_beat      = (idx_q == (bundle_q.cnt - BeatIdxW'(1)));
  assign bundle_ready_o = ~valid_q | (out_ready_i & last_beat);
  assign out_valid_o    = valid_q;
  assign out_beat_o     = bundle_q.beats[idx_q];
  assign out_pid_o      = bundle_q.pid_data1;
  assign out_ep_o       = bundle_q.endpoint;
  assign out_done_o     = bundle_q.transfer_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (bundle_valid_i && bundle_ready_o) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (valid_q && out_ready_i) begin
      if (last_beat) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + BeatIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bundle_valid_i && bundle_ready_o) begin
      bundle_q <= bundle_i;
    end
  end

endmodule

`default_nettype wire

@@ design/usb_in_data_packetizer.sv @@
// Top level of the USB IN data packetizer: stream ports, engine and beat serializer.
//
// Requests enter on the slave stream: tuser selects start, data byte, acknowledge or
// toggle reset; tdata carries endpoint, lengths and the payload byte. Each request
// yields one to three beats on the master stream: a status beat, a payload beat, or
// a payload beat followed by the inverted CRC16 low and high bytes (tlast on the
// high byte). A start on endpoint 0 with a zero count yields the two CRC beats.
// The first beat of a request is valid once the result register loads it from the
// input register, and can then be taken. Throughput: one request per cycle while
// each yields a single beat and the master side does not stall; a request with
// several beats holds the result register until all of its beats are taken, so
// the beat rate that the master side accepts sets the pace.
// Reset clears the transfer state, the data toggle and both stream stages; the CRC
// accumulator returns to all ones. When the receiver stalls, the result register
// holds its beat, the input register fills, and s_axis_tready drops until the
// pending beats drain.
`default_nettype none

module usb_in_data_packetizer
  import uidp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // [3:0] endpoint, [19:4] transfer_length, [35:20] max_length, [43:36] data_byte
  input  wire logic [47:0] s_axis_tdata,
  // [1:0] req_type
  input  wire logic [1:0]  s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] out_byte, [8] pid_data1, [12:9] packet_endpoint, [13] transfer_done
  output      logic [15:0] m_axis_tdata,
  // [1:0] status, [2] byte_valid
  output      logic [2:0]  m_axis_tuser,
  output      logic        m_axis_tlast
);

  logic           bundle_valid;
  logic           bundle_ready;
  bundle_t        bundle;
  beat_t          beat;
  logic           pid;
  logic [EpW-1:0] ep;
  logic           done;

  uidp_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_req_i       (s_axis_tuser),
    .in_ep_i        (s_axis_tdata[3:0]),
    .in_tlen_i      (s_axis_tdata[19:4]),
    .in_mlen_i      (s_axis_tdata[35:20]),
    .in_byte_i      (s_axis_tdata[43:36]),
    .bundle_valid_o (bundle_valid),
    .bundle_ready_i (bundle_ready),
    .bundle_o       (bundle)
  );

  uidp_serializer u_serializer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bundle_valid_i (bundle_valid),
    .bundle_ready_o (bundle_ready),
    .bundle_i       (bundle),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_beat_o     (beat),
    .out_pid_o      (pid),
    .out_ep_o       (ep),
    .out_done_o     (done)
  );

  assign m_axis_tdata = {2'b00, done, ep, pid, beat.out_byte};
  assign m_axis_tuser = {beat.byte_valid, beat.status};
  assign m_axis_tlast = beat.last;

`include "usb_in_data_packetizer_assert.svh"

  `UIDP_ASSERT_IMPL(a_last_is_byte, m_axis_tvalid && m_axis_tlast, beat.byte_valid && (beat.status == StOk))
  `UIDP_ASSERT_IMPL(a_err_no_byte, m_axis_tvalid && (beat.status != StOk), !beat.byte_valid)
  `UIDP_ASSERT_IMPL(a_busy_active, m_axis_tvalid && (beat.status == StBusy), !done)
  `UIDP_ASSERT_NEXT(a_stall_holds_beat, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(beat))

endmodule

`default_nettype wire
